### hw/rtl/psg_pkg.sv
package psg_pkg;

    localparam int HEADER_BYTES = 16;
    localparam int SIG_BYTES    = 4;

    localparam logic [7:0] MARKER_BYTE = 8'h1a;
    localparam logic [7:0] CMD_FRAME   = 8'hff;
    localparam logic [7:0] CMD_SKIP    = 8'hfe;
    localparam logic [7:0] CMD_END     = 8'hfd;
    localparam logic [7:0] REG_LAST    = 8'd15;

    localparam logic [1:0] KIND_REG_WRITE = 2'd0;
    localparam logic [1:0] KIND_FRAMES    = 2'd1;
    localparam logic [1:0] KIND_SUMMARY   = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_CMD,
        PH_ARG_SKIP,
        PH_ARG_REG,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [3:0]  reg_index;
        logic [7:0]  reg_value;
        logic [9:0]  frame_count;
        logic        accepted;
        logic [31:0] used_size;
        logic        last_result;
    } t_out_word;

    // up to two result words produced by one input word
    typedef struct packed {
        logic [1:0] count;
        t_out_word  first;
        t_out_word  second;
    } t_push;

    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h50;
            2'd1:    b = 8'h53;
            2'd2:    b = 8'h47;
            default: b = MARKER_BYTE;
        endcase
        return b;
    endfunction

endpackage

### hw/rtl/psg_parse.sv
module psg_parse
    import psg_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_take,
    input  t_in_word i_word,
    output t_push    o_push
);

    localparam int EW = (SIZE_BITS > 32) ? SIZE_BITS : 32;

    logic [SIZE_BITS-1:0] r_pos, n_pos;
    logic [SIZE_BITS-1:0] r_cons, n_cons;
    t_phase               r_phase, n_phase;
    logic                 r_hv, n_hv;
    logic [3:0]           r_pend, n_pend;

    logic [SIZE_BITS-1:0] nxt;
    logic [7:0]           b;
    logic                 ev_v;
    t_out_word            ev;
    t_out_word            sum;
    logic                 acc;
    logic [EW-1:0]        cons_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_cons  <= '0;
            r_phase <= PH_HEADER;
            r_hv    <= 1'b1;
            r_pend  <= '0;
        end else if (i_take) begin
            r_pos   <= n_pos;
            r_cons  <= n_cons;
            r_phase <= n_phase;
            r_hv    <= n_hv;
            r_pend  <= n_pend;
        end
    end

    always_comb begin
        b        = i_word.data_byte;
        nxt      = (&r_pos) ? r_pos : r_pos + 1'b1;
        n_pos    = nxt;
        n_cons   = r_cons;
        n_phase  = r_phase;
        n_hv     = r_hv;
        n_pend   = r_pend;
        ev_v     = 1'b0;
        ev       = '0;
        sum      = '0;
        o_push   = '0;

        unique case (r_phase)
            PH_HEADER: begin
                n_cons = nxt;
                if (r_pos < SIZE_BITS'(SIG_BYTES)) begin
                    if (b != sig_byte(r_pos[1:0])) begin
                        n_hv    = 1'b0;
                        n_phase = PH_DONE;
                    end
                end else if (b == CMD_FRAME) begin
                    n_phase        = PH_CMD;
                    ev_v           = 1'b1;
                    ev.event_kind  = KIND_FRAMES;
                    ev.frame_count = 10'd1;
                end else begin
                    n_phase = (r_pos >= SIZE_BITS'(HEADER_BYTES - 1)) ? PH_CMD : PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_cons = nxt;
                if (r_pos >= SIZE_BITS'(HEADER_BYTES - 1)) begin
                    n_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                if (b == CMD_FRAME) begin
                    n_cons         = nxt;
                    ev_v           = 1'b1;
                    ev.event_kind  = KIND_FRAMES;
                    ev.frame_count = 10'd1;
                end else if (b == CMD_SKIP) begin
                    n_phase = PH_ARG_SKIP;
                end else if (b == CMD_END) begin
                    n_cons  = nxt;
                    n_phase = PH_DONE;
                end else if (b <= REG_LAST) begin
                    n_pend  = b[3:0];
                    n_phase = PH_ARG_REG;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_ARG_SKIP: begin
                n_cons         = nxt;
                n_phase        = PH_CMD;
                ev_v           = 1'b1;
                ev.event_kind  = KIND_FRAMES;
                ev.frame_count = {b, 2'b00};
            end
            PH_ARG_REG: begin
                n_cons       = nxt;
                n_phase      = PH_CMD;
                ev_v         = 1'b1;
                ev.event_kind = KIND_REG_WRITE;
                ev.reg_index = r_pend;
                ev.reg_value = b;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        acc      = n_hv && (r_pos >= SIZE_BITS'(HEADER_BYTES));
        cons_ext = EW'(n_cons);
        sum.event_kind  = KIND_SUMMARY;
        sum.accepted    = acc;
        sum.last_result = 1'b1;
        if (acc) begin
            sum.used_size = (cons_ext > EW'(32'hffff_ffff)) ? 32'hffff_ffff : cons_ext[31:0];
        end

        if (i_word.final_byte) begin
            n_pos   = '0;
            n_cons  = '0;
            n_phase = PH_HEADER;
            n_hv    = 1'b1;
            n_pend  = '0;
            if (ev_v) begin
                o_push.count  = 2'd2;
                o_push.first  = ev;
                o_push.second = sum;
            end else begin
                o_push.count = 2'd1;
                o_push.first = sum;
            end
        end else if (ev_v) begin
            ev.last_result = 1'b1;
            o_push.count   = 2'd1;
            o_push.first   = ev;
        end

        if (!i_take) begin
            o_push.count = 2'd0;
        end
    end

endmodule

### hw/rtl/psg_ofifo.sv
module psg_ofifo
    import psg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    output logic      o_full,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    localparam int DEPTH = 4;

    t_out_word  r_mem [DEPTH];
    logic [1:0] r_wr, n_wr;
    logic [1:0] r_rd, n_rd;
    logic [2:0] r_count, n_count;
    logic       pop;

    assign o_valid = (r_count != 3'd0);
    assign o_word  = r_mem[r_rd];
    // room for two words is needed before taking another input word
    assign o_full  = (r_count > 3'(DEPTH - 2));
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_wr    = r_wr + i_push.count;
        n_rd    = r_rd + {1'b0, pop};
        n_count = r_count + {1'b0, i_push.count} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_push.second;
        end
    end

endmodule

### hw/rtl/psg_register_dump_parser_top.sv
// Parses a PSG register dump streamed in one byte per word, with final_byte set on the
// last byte. Each input word is decoded in the cycle it is accepted and its results go
// into a four-word output queue; one input word is taken every cycle while the queue has
// room for two results, so the sustained rate is one byte per cycle, limited only by the
// output side draining one result word per cycle (a final byte that also completes a
// command yields two words). Register writes and frame additions appear as they are
// decoded; a summary word follows the final byte and the parser then starts a new file.
// Events from a file that the summary rejects must be dropped by the consumer.
module psg_register_dump_parser_top
    import psg_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_push push;
    logic  full;
    logic  take;

    assign o_in_stall = full;
    assign take       = i_in_valid && !full;

    psg_parse #(
        .SIZE_BITS(SIZE_BITS)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_word  (i_in_word),
        .o_push  (push)
    );

    psg_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_word)
    );

endmodule

### hw/rtl/psg_checker.sv
module psg_checker
    import psg_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    a_stall_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with nothing queued");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.event_kind == KIND_SUMMARY |->
            o_out_word.last_result && (!o_out_word.accepted || o_out_word.used_size >= 32'd5))
        else $error("bad summary word");

    a_event_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.event_kind != KIND_SUMMARY |->
            !o_out_word.accepted && o_out_word.used_size == 32'd0
            && (o_out_word.event_kind == KIND_REG_WRITE
                || o_out_word.event_kind == KIND_FRAMES))
        else $error("bad event word");

    a_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.event_kind == KIND_FRAMES |->
            o_out_word.reg_index == 4'd0 && o_out_word.reg_value == 8'd0
            && (o_out_word.frame_count == 10'd1 || o_out_word.frame_count[1:0] == 2'b00))
        else $error("bad frame word");

endmodule

bind psg_register_dump_parser_top psg_checker u_psg_checker (.*);
